>>> rtl/header_length_frame_receiver_unit_macros.svh
// Assertion macros used by the frame receiver back end.
`ifndef HEADER_LENGTH_FRAME_RECEIVER_UNIT_MACROS_SVH
`define HEADER_LENGTH_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// condition that holds at every clock edge outside reset
`define HLFR_ASSERT(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define HLFR_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define HLFR_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define HLFR_ASSERT(name, cond, msg)
`define HLFR_ASSERT_IMP(name, ante, cons, msg)
`define HLFR_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

>>> rtl/hlfr_pkg.sv
// Shared types and constants of the frame receiver.
package hlfr_pkg;

   // frame store geometry
   localparam int FRAME_DEPTH = 64;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int HDR_LEN     = 2;
   localparam int LEN_POS     = 3;
   localparam int MAX_LEN     = FRAME_DEPTH - 3;

   // field widths
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 8;

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // input opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // result kinds
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_POLL  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN = 2'd2;

   // register reset values
   localparam logic [BYTE_W-1:0] HEADER_RST  = 8'h55;
   localparam logic [LEN_W-1:0]  MIN_LEN_RST = 6'd3;
   localparam logic [LEN_W-1:0]  MAX_LEN_RST = 6'd7;
   localparam logic [LEN_W-1:0]  FLEN_RST    = 6'd2;

   // work handed from front to back
   typedef struct packed {
      logic              is_poll;
      logic              was_ready;
      logic [BYTE_W-1:0] hdr;
      logic [ADDR_W-1:0] last_pos;
   } cmd_type;

   // frame store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } wr_type;

   // back-end status toward the front
   typedef struct packed {
      logic frame_done;
   } back_stat_type;

endpackage

>>> rtl/hlfr_front.sv
// Front end: header hunt, length check, frame store writes and command issue.
module hlfr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic                                 req_opcode,
   input  logic [hlfr_pkg::BYTE_W-1:0]          req_rx_byte,
   input  logic                                 csr_we,
   input  logic [hlfr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hlfr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 q_full,
   output logic                                 q_push,
   output hlfr_pkg::cmd_type                    q_cmd,
   output hlfr_pkg::wr_type                     st_wr,
   input  hlfr_pkg::back_stat_type              back_stat
);

   logic                              accept;
   logic [hlfr_pkg::BYTE_W-1:0]       header_ff;
   logic [hlfr_pkg::LEN_W-1:0]        min_len_ff;
   logic [hlfr_pkg::LEN_W-1:0]        max_len_ff;
   logic                              in_frame_ff, in_frame_in;
   logic                              hdr_seen_ff, hdr_seen_in;
   logic [hlfr_pkg::LEN_W-1:0]        flen_ff, flen_in;
   logic [hlfr_pkg::CNT_W-1:0]        bcnt_ff, bcnt_in;
   logic                              pending_ff, pending_in;
   logic [hlfr_pkg::BYTE_W-1:0]       fhdr_ff, fhdr_in;
   logic                              busy_ff, busy_in;
   logic [hlfr_pkg::CNT_W-1:0]        bcnt_inc;
   logic [hlfr_pkg::LEN_W-1:0]        flen_eff;
   logic                              len_bad;

   // stall the input while a frame is being read out of the store or the command queue is full
   assign req_tready = !busy_ff && !q_full;
   assign accept     = req_tvalid && req_tready;

   assign bcnt_inc = bcnt_ff + hlfr_pkg::CNT_W'(1);
   assign len_bad  = (req_rx_byte < {2'b00, min_len_ff})
                  || (req_rx_byte > {2'b00, max_len_ff})
                  || (req_rx_byte == '0)
                  || (req_rx_byte > hlfr_pkg::BYTE_W'(hlfr_pkg::MAX_LEN));
   assign flen_eff = (bcnt_ff == hlfr_pkg::CNT_W'(hlfr_pkg::LEN_POS))
                   ? req_rx_byte[hlfr_pkg::LEN_W-1:0] : flen_ff;

   // receive state update for one transaction
   always_comb begin
      in_frame_in = in_frame_ff;
      hdr_seen_in = hdr_seen_ff;
      flen_in     = flen_ff;
      bcnt_in     = bcnt_ff;
      pending_in  = pending_ff;
      fhdr_in     = fhdr_ff;
      q_push      = 1'b0;
      q_cmd       = '0;
      st_wr       = '0;
      if (accept) begin
         if (req_opcode == hlfr_pkg::OP_POLL) begin
            q_push          = 1'b1;
            q_cmd.is_poll   = 1'b1;
            q_cmd.was_ready = pending_ff;
            pending_in      = 1'b0;
         end else if (!in_frame_ff) begin
            if (req_rx_byte == header_ff) begin
               if (hdr_seen_ff) begin
                  hdr_seen_in = 1'b0;
                  in_frame_in = 1'b1;
                  fhdr_in     = req_rx_byte;
                  bcnt_in     = hlfr_pkg::CNT_W'(hlfr_pkg::HDR_LEN);
               end else begin
                  hdr_seen_in = 1'b1;
               end
            end else begin
               hdr_seen_in = 1'b0;
               bcnt_in     = '0;
            end
         end else if (bcnt_ff >= hlfr_pkg::CNT_W'(hlfr_pkg::FRAME_DEPTH)) begin
            in_frame_in = 1'b0;
         end else begin
            st_wr.en   = 1'b1;
            st_wr.addr = bcnt_ff[hlfr_pkg::ADDR_W-1:0];
            st_wr.data = req_rx_byte;
            bcnt_in    = bcnt_inc;
            if (bcnt_ff == hlfr_pkg::CNT_W'(hlfr_pkg::LEN_POS) && len_bad) begin
               // length out of window or unusable: abort
               flen_in     = min_len_ff;
               in_frame_in = 1'b0;
            end else begin
               flen_in = flen_eff;
               if (bcnt_inc > hlfr_pkg::CNT_W'(hlfr_pkg::LEN_POS)
                   && bcnt_inc == ({1'b0, flen_eff} + hlfr_pkg::CNT_W'(3))) begin
                  in_frame_in = 1'b0;
                  if (!pending_ff) begin
                     pending_in     = 1'b1;
                     q_push         = 1'b1;
                     q_cmd.is_poll  = 1'b0;
                     q_cmd.hdr      = fhdr_ff;
                     q_cmd.last_pos = bcnt_ff[hlfr_pkg::ADDR_W-1:0];
                  end
               end
            end
         end
      end
   end

   // store is owned by the back end from frame issue until its last byte
   always_comb begin
      busy_in = busy_ff;
      if (back_stat.frame_done) begin
         busy_in = 1'b0;
      end
      if (q_push && !q_cmd.is_poll) begin
         busy_in = 1'b1;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= hlfr_pkg::HEADER_RST;
         min_len_ff <= hlfr_pkg::MIN_LEN_RST;
         max_len_ff <= hlfr_pkg::MAX_LEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            hlfr_pkg::CSR_HEADER:  header_ff  <= csr_wdata;
            hlfr_pkg::CSR_MIN_LEN: min_len_ff <= csr_wdata[hlfr_pkg::LEN_W-1:0];
            hlfr_pkg::CSR_MAX_LEN: max_len_ff <= csr_wdata[hlfr_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // receive state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         hdr_seen_ff <= 1'b0;
         flen_ff     <= hlfr_pkg::FLEN_RST;
         bcnt_ff     <= '0;
         pending_ff  <= 1'b0;
         busy_ff     <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         hdr_seen_ff <= hdr_seen_in;
         flen_ff     <= flen_in;
         bcnt_ff     <= bcnt_in;
         pending_ff  <= pending_in;
         busy_ff     <= busy_in;
      end
   end

   // header value of the frame in progress
   always_ff @(posedge clock) begin
      fhdr_ff <= fhdr_in;
   end

endmodule

>>> rtl/hlfr_cmd_queue.sv
// Two-entry command queue between front and back end.
module hlfr_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hlfr_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output hlfr_pkg::cmd_type    head_cmd,
   output logic                 full,
   output logic                 empty
);

   hlfr_pkg::cmd_type               entry_ff [hlfr_pkg::QUEUE_DEPTH];
   logic [hlfr_pkg::QPTR_W-1:0]     wptr_ff;
   logic [hlfr_pkg::QPTR_W-1:0]     rptr_ff;
   logic [hlfr_pkg::QCNT_W-1:0]     count_ff;

   assign full     = (count_ff == hlfr_pkg::QCNT_W'(hlfr_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entry_ff[rptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + hlfr_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + hlfr_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + hlfr_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - hlfr_pkg::QCNT_W'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/hlfr_back.sv
// Back end: frame store memory, readout sequencer and result register.
`include "header_length_frame_receiver_unit_macros.svh"

module hlfr_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hlfr_pkg::wr_type                      st_wr,
   input  hlfr_pkg::cmd_type                     head_cmd,
   input  logic                                  q_empty,
   output logic                                  q_pop,
   output hlfr_pkg::back_stat_type               back_stat,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [hlfr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POLL,
      ST_READ,
      ST_SEND
   } state_type;

   state_type                         state_ff;
   hlfr_pkg::cmd_type                 cmd_ff;
   logic [hlfr_pkg::ADDR_W-1:0]       pos_ff;
   logic [hlfr_pkg::BYTE_W-1:0]       store_mem [hlfr_pkg::FRAME_DEPTH];
   logic [hlfr_pkg::BYTE_W-1:0]       rd_data_ff;
   logic                              out_valid_ff;
   logic                              out_kind_ff;
   logic [hlfr_pkg::BYTE_W-1:0]       out_byte_ff;
   logic [hlfr_pkg::ADDR_W-1:0]       out_pos_ff;
   logic                              out_last_ff;
   logic                              out_ready_ff;
   logic                              out_free;
   logic                              out_load;
   logic                              send_last;
   logic [hlfr_pkg::BYTE_W-1:0]       send_byte;

   assign out_free  = !out_valid_ff || rsp_tready;
   // result register takes a new transaction in these states
   assign out_load  = out_free && (state_ff == ST_POLL || state_ff == ST_SEND);
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign send_last = (pos_ff == cmd_ff.last_pos);
   assign send_byte = (pos_ff < hlfr_pkg::ADDR_W'(hlfr_pkg::HDR_LEN))
                    ? cmd_ff.hdr : rd_data_ff;
   assign back_stat.frame_done = (state_ff == ST_SEND) && out_free && send_last;

   // frame store: one write port from the front, registered read here
   always_ff @(posedge clock) begin
      if (st_wr.en) begin
         store_mem[st_wr.addr] <= st_wr.data;
      end
      rd_data_ff <= store_mem[pos_ff];
   end

   // readout sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  cmd_ff <= head_cmd;
                  pos_ff <= '0;
                  state_ff <= head_cmd.is_poll ? ST_POLL : ST_READ;
               end
            end
            ST_POLL: begin
               if (out_free) begin
                  out_kind_ff  <= hlfr_pkg::KIND_POLL;
                  out_byte_ff  <= '0;
                  out_pos_ff   <= '0;
                  out_last_ff  <= 1'b1;
                  out_ready_ff <= cmd_ff.was_ready;
                  state_ff     <= ST_IDLE;
               end
            end
            // store address settles, read data arrives next cycle
            ST_READ: begin
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (out_free) begin
                  out_kind_ff  <= hlfr_pkg::KIND_FRAME;
                  out_byte_ff  <= send_byte;
                  out_pos_ff   <= pos_ff;
                  out_last_ff  <= send_last;
                  out_ready_ff <= 1'b0;
                  if (send_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     pos_ff   <= pos_ff + hlfr_pkg::ADDR_W'(1);
                     state_ff <= ST_READ;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result port, tdata: frame_byte, byte_position, was_ready, zero pad
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_ready_ff, out_pos_ff, out_byte_ff};

   `HLFR_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "pop from empty command queue")
   `HLFR_ASSERT_NXT(a_done_idle, back_stat.frame_done, state_ff == ST_IDLE && out_valid_ff && out_last_ff, "frame end without last result")
   `HLFR_ASSERT_NXT(a_send_loads, state_ff == ST_SEND && out_free, out_valid_ff && out_kind_ff == hlfr_pkg::KIND_FRAME, "frame byte not loaded")
   `HLFR_ASSERT_IMP(a_write_idle, st_wr.en, state_ff != ST_READ && state_ff != ST_SEND, "store write in readout")

endmodule

>>> rtl/header_length_frame_receiver_unit.sv
// Top level of the double-header, length-field serial frame receiver.
//
//   Port group   Direction  Contents
//   req_*        in         tuser[0] opcode, tdata[7:0] rx_byte
//   rsp_*        out        tuser[0] kind, tdata: [7:0] frame_byte, [13:8] byte_position,
//                           [14] was_ready, [15] zero; tlast = last
//   csr_*        in         write enable, register index, write data
//
// A received byte or a poll is taken whenever the front is free.
// A completed frame is read out byte by byte, each byte through the store read
// port and then the result register, once the back end has picked up its
// command; the input stalls until the last byte is loaded. A poll answer goes
// through the command queue and the poll state into the result register when the back end is idle.
// Reset is synchronous; the frame store is not cleared, only written entries are read.
// A stalled result port holds the back end; the front keeps taking bytes unless the store is busy or the queue is full.
module header_length_frame_receiver_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // rx_byte
   input  logic [0:0]                           req_tuser,   // opcode
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [hlfr_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // frame_byte, byte_position, was_ready
   output logic [0:0]                           rsp_tuser,   // kind
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [hlfr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hlfr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic                       q_push;
   logic                       q_pop;
   logic                       q_full;
   logic                       q_empty;
   hlfr_pkg::cmd_type          push_cmd;
   hlfr_pkg::cmd_type          head_cmd;
   hlfr_pkg::wr_type           st_wr;
   hlfr_pkg::back_stat_type    back_stat;

   hlfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_opcode  (req_tuser[0]),
      .req_rx_byte (req_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd),
      .st_wr       (st_wr),
      .back_stat   (back_stat)
   );

   hlfr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   hlfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .st_wr      (st_wr),
      .head_cmd   (head_cmd),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .back_stat  (back_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser[0]),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/hlfr_frame_checker.sv
// Checker for the frame receiver: predicts result transactions and compares them.
`timescale 1ns / 100ps

module hlfr_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // rx_byte
   input  logic [0:0]                      req_tuser,   // opcode
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [hlfr_pkg::RSP_DATA_W-1:0] rsp_tdata,   // frame_byte, byte_position, was_ready, pad
   input  logic [0:0]                      rsp_tuser,   // kind
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [hlfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hlfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              open_count,
   output int                              checked_count,
   output int                              frames_seen
);

   // one result transaction as the receiver should emit it
   typedef struct packed {
      logic                        kind;
      logic [hlfr_pkg::BYTE_W-1:0] data;
      logic [hlfr_pkg::LEN_W-1:0]  pos;
      logic                        last;
      logic                        ready;
   } rx_result_type;

   rx_result_type expected_q[$];
   rx_result_type head_result;

   // register copies
   logic [hlfr_pkg::BYTE_W-1:0] hdr_cfg;
   logic [hlfr_pkg::LEN_W-1:0]  min_cfg;
   logic [hlfr_pkg::LEN_W-1:0]  max_cfg;

   // receive state
   logic                        rcv_in_frame;
   logic                        rcv_hdr_seen;
   logic [hlfr_pkg::LEN_W-1:0]  rcv_len;
   logic [hlfr_pkg::CNT_W-1:0]  rcv_count;
   logic                        rcv_pending;
   logic [hlfr_pkg::BYTE_W-1:0] frame_mem [hlfr_pkg::FRAME_DEPTH];

   task automatic clear_receiver();
      hdr_cfg      = hlfr_pkg::HEADER_RST;
      min_cfg      = hlfr_pkg::MIN_LEN_RST;
      max_cfg      = hlfr_pkg::MAX_LEN_RST;
      rcv_in_frame = 1'b0;
      rcv_hdr_seen = 1'b0;
      rcv_len      = hlfr_pkg::FLEN_RST;
      rcv_count    = '0;
      rcv_pending  = 1'b0;
      expected_q.delete();
   endtask

   // advance the receiver by one input transaction, queue what it emits
   task automatic predict_item(input logic op, input logic [hlfr_pkg::BYTE_W-1:0] b);
      int len;
      int i;
      if (op == hlfr_pkg::OP_POLL) begin
         expected_q.push_back('{hlfr_pkg::KIND_POLL, 8'h00, 6'd0, 1'b1, rcv_pending});
         rcv_pending = 1'b0;
         return;
      end
      // hunting for the header pair
      if (!rcv_in_frame) begin
         if (b == hdr_cfg) begin
            if (rcv_hdr_seen) begin
               rcv_hdr_seen = 1'b0;
               rcv_in_frame = 1'b1;
               frame_mem[0] = b;
               frame_mem[1] = b;
               rcv_count    = 7'd2;
            end else begin
               rcv_hdr_seen = 1'b1;
            end
         end else begin
            rcv_hdr_seen = 1'b0;
            rcv_count    = '0;
         end
         return;
      end
      if (int'(rcv_count) >= hlfr_pkg::FRAME_DEPTH) begin
         rcv_in_frame = 1'b0;
         return;
      end
      frame_mem[rcv_count[hlfr_pkg::ADDR_W-1:0]] = b;
      // length byte: out of window or unusable aborts the frame
      if (int'(rcv_count) == hlfr_pkg::LEN_POS) begin
         len = int'(b);
         if (len < int'(min_cfg) || len > int'(max_cfg) || len == 0 ||
             len + 3 > hlfr_pkg::FRAME_DEPTH) begin
            rcv_len      = min_cfg;
            rcv_in_frame = 1'b0;
            rcv_count    = rcv_count + 1'b1;
            return;
         end
         rcv_len = b[hlfr_pkg::LEN_W-1:0];
      end
      rcv_count = rcv_count + 1'b1;
      // frame complete: deliver unless an earlier one is still pending
      if (int'(rcv_count) > hlfr_pkg::LEN_POS && int'(rcv_count) == int'(rcv_len) + 3) begin
         rcv_in_frame = 1'b0;
         if (!rcv_pending) begin
            rcv_pending = 1'b1;
            for (i = 0; i < int'(rcv_count); i++)
               expected_q.push_back('{hlfr_pkg::KIND_FRAME, frame_mem[i],
                                      i[hlfr_pkg::LEN_W-1:0],
                                      (i + 1 == int'(rcv_count)), 1'b0});
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_receiver();
      end else begin
         // result side first: it can only belong to an earlier input
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            if (expected_q.size() == 0) begin
               $error("unexpected result transaction: kind %0d, tdata %0h",
                      rsp_tuser[0], rsp_tdata);
               fail_count++;
            end else begin
               head_result = expected_q.pop_front();
               check_field("kind", 8'(head_result.kind), 8'(rsp_tuser[0]));
               check_field("frame_byte", head_result.data, rsp_tdata[7:0]);
               check_field("byte_position", 8'(head_result.pos), 8'(rsp_tdata[13:8]));
               check_field("last", 8'(head_result.last), 8'(rsp_tlast));
               check_field("was_ready", 8'(head_result.ready), 8'(rsp_tdata[14]));
               check_field("pad", 8'h00, 8'(rsp_tdata[15]));
               if (head_result.kind == hlfr_pkg::KIND_FRAME && head_result.last)
                  frames_seen++;
            end
         end
         // register writes
         if (csr_we) begin
            case (csr_index)
               hlfr_pkg::CSR_HEADER:  hdr_cfg = csr_wdata;
               hlfr_pkg::CSR_MIN_LEN: min_cfg = csr_wdata[hlfr_pkg::LEN_W-1:0];
               hlfr_pkg::CSR_MAX_LEN: max_cfg = csr_wdata[hlfr_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_item(req_tuser[0], req_tdata);
      end
      open_count = expected_q.size();
   end

endmodule

>>> tb/tb.sv
// Testbench top: drives the frame receiver, varies registers and gives the verdict.
`timescale 1ns / 100ps

module tb;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES  = 50;
   localparam int PHASE_ITEMS   = 8;

   typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_BURSTY} sink_mode_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata   = 8'h00;
   logic [0:0]                      req_tuser   = hlfr_pkg::OP_BYTE;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [hlfr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]                      rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_we      = 1'b0;
   logic [hlfr_pkg::CSR_IDX_W-1:0]  csr_index   = hlfr_pkg::CSR_HEADER;
   logic [hlfr_pkg::CSR_DATA_W-1:0] csr_wdata   = 8'h00;

   int fail_count;
   int open_count;
   int checked_count;
   int frames_seen;
   int cycle_count    = 0;
   int items_sent     = 0;
   int settings_used  = 0;
   int burst_left     = 0;

   // stimulus-side view of the registers
   logic [hlfr_pkg::BYTE_W-1:0] hdr_now;
   logic [hlfr_pkg::LEN_W-1:0]  min_now;
   logic [hlfr_pkg::LEN_W-1:0]  max_now;

   // sink stall pattern state
   sink_mode_type sink_mode = SINK_OPEN;
   int            sink_left = 0;
   int            sink_hold = 0;
   logic          sink_open = 1'b1;

   header_length_frame_receiver_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   hlfr_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .open_count    (open_count),
      .checked_count (checked_count),
      .frames_seen   (frames_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result sink: open stretches, random stalls, and long stall runs
   always @(negedge clock) begin
      if (sink_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 2));
         sink_left = $urandom_range(20, 120);
      end
      sink_left--;
      case (sink_mode)
         SINK_OPEN:   sink_open = 1'b1;
         SINK_RANDOM: sink_open = ($urandom_range(0, 3) != 0);
         default: begin
            if (sink_hold == 0) begin
               sink_open = ~sink_open;
               sink_hold = sink_open ? $urandom_range(1, 4) : $urandom_range(1, 20);
            end
            sink_hold--;
         end
      endcase
      rsp_tready <= sink_open;
   end

   // one input transaction, in bursts with random gaps between them
   task automatic send_item(input logic op, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= op;
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(hlfr_pkg::OP_BYTE, b);
   endtask

   task automatic send_poll();
      send_item(hlfr_pkg::OP_POLL, 8'($urandom_range(0, 255)));
   endtask

   function automatic logic [7:0] rand_data();
      return ($urandom_range(0, 7) == 0) ? hdr_now : 8'($urandom_range(0, 255));
   endfunction

   // length inside the window, biased to its edges and to short frames
   function automatic logic [7:0] pick_good_len();
      int span;
      if (min_now > max_now) return 8'($urandom_range(0, 255));
      span = int'(max_now) - int'(min_now);
      if (span > 6) span = 6;
      case ($urandom_range(0, 9))
         0:       return 8'(max_now);
         1:       return 8'(min_now);
         default: return 8'(int'(min_now) + $urandom_range(0, span));
      endcase
   endfunction

   function automatic logic [7:0] pick_bad_len();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'(int'(max_now) + 1 + $urandom_range(0, 3));
         2:       return (min_now > 0) ? 8'($urandom_range(0, int'(min_now) - 1)) : 8'h00;
         default: return 8'($urandom_range(hlfr_pkg::MAX_LEN + 1, 255));
      endcase
   endfunction

   // header pair, one byte, length, then body; aborted frames get a few stray bytes
   task automatic send_frame(input logic [7:0] len_byte);
      int n;
      send_byte(hdr_now);
      send_byte(hdr_now);
      send_byte(rand_data());
      send_byte(len_byte);
      if (len_byte >= min_now && len_byte <= max_now && len_byte != 0 &&
          int'(len_byte) <= hlfr_pkg::MAX_LEN)
         n = int'(len_byte) - 1;
      else
         n = $urandom_range(0, 3);
      repeat (n) send_byte(rand_data());
   endtask

   // wait until every expected result is in and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] h, input logic [hlfr_pkg::LEN_W-1:0] mn,
                             input logic [hlfr_pkg::LEN_W-1:0] mx);
      csr_we    <= 1'b1;
      csr_index <= hlfr_pkg::CSR_HEADER;
      csr_wdata <= h;
      @(negedge clock);
      csr_index <= hlfr_pkg::CSR_MIN_LEN;
      csr_wdata <= 8'(mn);
      @(negedge clock);
      csr_index <= hlfr_pkg::CSR_MAX_LEN;
      csr_wdata <= 8'(mx);
      @(negedge clock);
      csr_we  <= 1'b0;
      hdr_now = h;
      min_now = mn;
      max_now = mx;
      settings_used++;
   endtask

   // random traffic: mostly well-formed frames, some broken ones, noise and polls
   task automatic run_phase(input int quota);
      int start;
      int r;
      start = items_sent;
      while (items_sent - start < quota) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            send_frame(pick_good_len());
            if ($urandom_range(0, 1) == 1) send_poll();
         end else if (r < 65) begin
            send_frame(pick_bad_len());
         end else if (r < 80) begin
            repeat ($urandom_range(1, 4))
               send_byte(($urandom_range(0, 2) == 0) ? hdr_now : 8'($urandom_range(0, 255)));
         end else begin
            send_poll();
         end
      end
      settle();
   endtask

   initial begin
      hdr_now = hlfr_pkg::HEADER_RST;
      min_now = hlfr_pkg::MIN_LEN_RST;
      max_now = hlfr_pkg::MAX_LEN_RST;
      settings_used = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: poll with nothing pending, hunt restarts
      send_poll();
      send_byte(8'h12);
      send_byte(hdr_now);
      send_byte(8'hAA);
      // shortest window frame, header value also used as data
      send_byte(hdr_now);
      send_byte(hdr_now);
      send_byte(hdr_now);
      send_byte(8'd3);
      send_byte(8'h00);
      send_byte(8'hFF);
      // length below, then above the window
      send_byte(hdr_now);
      send_byte(hdr_now);
      send_byte(8'h01);
      send_byte(8'd2);
      send_byte(hdr_now);
      send_byte(hdr_now);
      send_byte(8'h01);
      send_byte(8'd8);
      // complete frame while the first is still pending: dropped
      send_byte(hdr_now);
      send_byte(hdr_now);
      send_byte(8'h5A);
      send_byte(8'd3);
      send_byte(8'h80);
      send_byte(8'h7F);
      // pending flag reported, then cleared
      send_poll();
      send_poll();
      settle();

      // register extremes, a single-length window, an empty window
      set_config(8'h00, 6'd0, 6'(hlfr_pkg::MAX_LEN));
      run_phase(PHASE_ITEMS);
      set_config(8'hFF, 6'd1, 6'd1);
      run_phase(6);
      set_config(8'hA5, 6'd10, 6'd5);
      run_phase(5);
      repeat (3) begin
         min_now = 6'($urandom_range(0, 12));
         set_config(8'($urandom_range(0, 255)), min_now,
                    6'(int'(min_now) + $urandom_range(0, 10)));
         run_phase(PHASE_ITEMS);
      end
      // one of the largest frames, with the pending flag cleared first
      set_config(8'($urandom_range(0, 255)), 6'(hlfr_pkg::MAX_LEN), 6'(hlfr_pkg::MAX_LEN));
      send_poll();
      send_frame(8'(hlfr_pkg::MAX_LEN));
      send_poll();
      settle();
      set_config(hlfr_pkg::HEADER_RST, hlfr_pkg::MIN_LEN_RST, hlfr_pkg::MAX_LEN_RST);
      run_phase(PHASE_ITEMS);

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d input transactions under %0d register settings.",
               items_sent, settings_used);
      $display("Checked %0d result transactions, %0d delivered frames among them.",
               checked_count, frames_seen);
      if (fail_count == 0 && open_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
